// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/par_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_pkg
// Types, widths, codes and the sine table for the point rotation core.
// ----------------------------------------------------------------------------
package par_pkg;

  // Coordinate and trig formats
  localparam int COORD_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int ANGLE_STEPS    = 360;

  // Register widths
  localparam int ANGLE_W    = 10;
  localparam int SCREEN_W   = 12;
  localparam int CENTRE_W   = SCREEN_W - 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = SCREEN_W;

  // Reduced angle 0..359
  localparam int DEG_W = 9;

  // Derived datapath widths
  localparam int DELTA_W = ((COORD_BITS > CENTRE_W + 1) ? COORD_BITS : CENTRE_W + 1) + 1;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int PROD_W  = DELTA_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int QUOT_W  = SUM_W - TRIG_FRAC_BITS;

  // Table rescale from Q1.15 to the trig format
  localparam int QTAB_FRAC = 15;
  localparam int QTAB_W    = QTAB_FRAC + 2;
  localparam int TRIG_UP   = (TRIG_FRAC_BITS >= QTAB_FRAC) ? TRIG_FRAC_BITS - QTAB_FRAC : 0;
  localparam int TRIG_DN   = (TRIG_FRAC_BITS >= QTAB_FRAC) ? 0 : QTAB_FRAC - TRIG_FRAC_BITS;
  localparam int MAG_W     = QTAB_W + TRIG_UP;
  localparam int QIDX_W    = 7;

  // Degree landmarks
  localparam logic [DEG_W:0] DEG_QUARTER = (DEG_W + 1)'(ANGLE_STEPS / 4);
  localparam logic [DEG_W:0] DEG_HALF    = (DEG_W + 1)'(ANGLE_STEPS / 2);
  localparam logic [DEG_W:0] DEG_3QUART  = (DEG_W + 1)'(3 * ANGLE_STEPS / 4);
  localparam logic [DEG_W:0] DEG_FULL    = (DEG_W + 1)'(ANGLE_STEPS);
  localparam logic signed [ANGLE_W:0] ANGLE_TURN = (ANGLE_W + 1)'(ANGLE_STEPS);

  // Axis selector codes
  typedef enum logic [1:0] {
    FUNC_ROT_X = 2'd0,
    FUNC_ROT_Y = 2'd1,
    FUNC_ROT_Z = 2'd2
  } par_func_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_SCREEN_W = 3'd3,
    REG_SCREEN_H = 3'd4
  } par_reg_t;

  // Request payloads
  typedef struct packed {
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic                         last_point;
  } par_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         last_point_out;
  } par_out_t;

  // Sine and cosine of one angle
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } par_trig_t;

  // First quadrant of round(sin(k deg) * 32768), k = 0..90
  localparam logic [QTAB_W-1:0] QSINE [0:90] = '{
    17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,  17'd2856,  17'd3425,
    17'd3993,  17'd4560,  17'd5126,  17'd5690,  17'd6252,  17'd6813,  17'd7371,
    17'd7927,  17'd8481,  17'd9032,  17'd9580,  17'd10126, 17'd10668, 17'd11207,
    17'd11743, 17'd12275, 17'd12803, 17'd13328, 17'd13848, 17'd14365, 17'd14876,
    17'd15384, 17'd15886, 17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
    17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622, 17'd21063, 17'd21498,
    17'd21926, 17'd22348, 17'd22763, 17'd23170, 17'd23571, 17'd23965, 17'd24351,
    17'd24730, 17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510, 17'd26842,
    17'd27166, 17'd27482, 17'd27789, 17'd28088, 17'd28378, 17'd28660, 17'd28932,
    17'd29197, 17'd29452, 17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
    17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499, 17'd31651, 17'd31795,
    17'd31928, 17'd32052, 17'd32166, 17'd32270, 17'd32365, 17'd32449, 17'd32524,
    17'd32588, 17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763, 17'd32768
  };

  // Sine of a whole-degree angle 0..359 by quadrant folding
  function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [DEG_W:0] k);
    logic [DEG_W:0]           d;
    logic                     neg;
    logic [MAG_W-1:0]         m;
    logic signed [TRIG_W-1:0] r;
    neg = 1'b0;
    if (k <= DEG_QUARTER) begin
      d = k;
    end else if (k <= DEG_HALF) begin
      d = DEG_HALF - k;
    end else if (k <= DEG_3QUART) begin
      d   = k - DEG_HALF;
      neg = 1'b1;
    end else begin
      d   = DEG_FULL - k;
      neg = 1'b1;
    end
    m = (MAG_W'(QSINE[d[QIDX_W-1:0]]) << TRIG_UP) >> TRIG_DN;
    r = $signed(TRIG_W'(m));
    return neg ? -r : r;
  endfunction

endpackage

// ===== rtl/point_axis_rotation_core.sv =====
`timescale 1ns / 1ps
// An accepted request passes the stage 1 to stage 5 registers before out_valid.
// Throughput: one point per cycle while out_stall is low; every stage holds its own
//   valid bit and advances when the stage after it is empty or moving, so bubbles close up.
// The deepest path is the 17x17 product stage and the three-term sum stage.
// Reset clears all stage valid bits and the five configuration registers.
// ----------------------------------------------------------------------------
// point_axis_rotation_core
// Five-stage pipeline that rotates one 3D point about a chosen axis around
// the screen centre by a configured whole-degree angle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_axis_rotation_core
  import par_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  par_in_t               in_data,
  // request out
  output logic                  out_valid,
  input  logic                  out_stall,
  output par_out_t              out_data
);

  // Configuration registers
  logic [ANGLE_W-1:0]  angle_x_r;
  logic [ANGLE_W-1:0]  angle_y_r;
  logic [ANGLE_W-1:0]  angle_z_r;
  logic [SCREEN_W-1:0] screen_w_r;
  logic [SCREEN_W-1:0] screen_h_r;

  // Stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: reduced angle and centred operands
  par_in_t                   p1_r;
  logic [DEG_W-1:0]          deg1_r, deg1_nxt;
  logic signed [DELTA_W-1:0] du1_r, du1_nxt;
  logic signed [DELTA_W-1:0] dv1_r, dv1_nxt;
  logic [CENTRE_W-1:0]       cu1_r, cu1_nxt;
  logic [CENTRE_W-1:0]       cv1_r, cv1_nxt;

  // Stage 2: sine and cosine
  par_in_t                   p2_r;
  par_trig_t                 trig2_r, trig2_nxt;
  logic signed [DELTA_W-1:0] du2_r, dv2_r;
  logic [CENTRE_W-1:0]       cu2_r, cv2_r;

  // Stage 3: products
  par_in_t                   p3_r;
  logic signed [PROD_W-1:0]  uc3_r, vs3_r, us3_r, vc3_r;
  logic [CENTRE_W-1:0]       cu3_r, cv3_r;

  // Stage 4: sums
  par_in_t                   p4_r;
  logic signed [SUM_W-1:0]   suma4_r, suma4_nxt;
  logic signed [SUM_W-1:0]   sumb4_r, sumb4_nxt;

  // Stage 5: result
  par_out_t                  out_r, out_nxt;
  logic signed [COORD_BITS-1:0] coord_a, coord_b;

  // Advance a stage when it is empty or the next one takes its request
  assign rdy5      = !v5_r || !out_stall;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_stall  = !rdy1;
  assign out_valid = v5_r;
  assign out_data  = out_r;

  // Hold configuration and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r  <= '0;
      angle_y_r  <= '0;
      angle_z_r  <= '0;
      screen_w_r <= '0;
      screen_h_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ANGLE_X:  angle_x_r  <= cfg_wdata[ANGLE_W-1:0];
          REG_ANGLE_Y:  angle_y_r  <= cfg_wdata[ANGLE_W-1:0];
          REG_ANGLE_Z:  angle_z_r  <= cfg_wdata[ANGLE_W-1:0];
          REG_SCREEN_W: screen_w_r <= cfg_wdata[SCREEN_W-1:0];
          REG_SCREEN_H: screen_h_r <= cfg_wdata[SCREEN_W-1:0];
          default: ;
        endcase
      end
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: pick the angle, reduce it, and map the point onto a rotation pair
  always_comb begin
    logic [ANGLE_W-1:0]        ang_sel;
    logic signed [ANGLE_W:0]   ang_ext;
    logic signed [ANGLE_W:0]   ang_red;
    logic [CENTRE_W-1:0]       cx;
    logic [CENTRE_W-1:0]       cy;
    logic signed [DELTA_W-1:0] xe;
    logic signed [DELTA_W-1:0] ye;
    logic signed [DELTA_W-1:0] ze;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    case (in_data.func)
      FUNC_ROT_X: ang_sel = angle_x_r;
      FUNC_ROT_Y: ang_sel = angle_y_r;
      default:    ang_sel = angle_z_r;
    endcase
    ang_ext = $signed({ang_sel[ANGLE_W-1], ang_sel});
    if (ang_ext < -ANGLE_TURN) begin
      ang_red = ang_ext + ANGLE_TURN + ANGLE_TURN;
    end else if (ang_ext < 0) begin
      ang_red = ang_ext + ANGLE_TURN;
    end else if (ang_ext >= ANGLE_TURN) begin
      ang_red = ang_ext - ANGLE_TURN;
    end else begin
      ang_red = ang_ext;
    end
    deg1_nxt = ang_red[DEG_W-1:0];

    cx = screen_w_r[SCREEN_W-1:1];
    cy = screen_h_r[SCREEN_W-1:1];
    xe = DELTA_W'(in_data.in_x);
    ye = DELTA_W'(in_data.in_y);
    ze = DELTA_W'(in_data.in_z);
    dx = xe - $signed({{(DELTA_W-CENTRE_W){1'b0}}, cx});
    dy = ye - $signed({{(DELTA_W-CENTRE_W){1'b0}}, cy});

    // u' = du*cos - dv*sin + cu,  v' = du*sin + dv*cos + cv
    case (in_data.func)
      FUNC_ROT_X: begin
        du1_nxt = dy;
        cu1_nxt = cy;
        dv1_nxt = ze;
        cv1_nxt = '0;
      end
      FUNC_ROT_Y: begin
        du1_nxt = ze;
        cu1_nxt = '0;
        dv1_nxt = dx;
        cv1_nxt = cx;
      end
      default: begin
        du1_nxt = dx;
        cu1_nxt = cx;
        dv1_nxt = dy;
        cv1_nxt = cy;
      end
    endcase
  end

  // Stage 2: table lookup
  par_trig u_trig (
    .deg  (deg1_r),
    .trig (trig2_nxt)
  );

  // Stage 4: combine products with the centre
  always_comb begin
    suma4_nxt = SUM_W'(uc3_r) - SUM_W'(vs3_r) + $signed(SUM_W'(cu3_r) << TRIG_FRAC_BITS);
    sumb4_nxt = SUM_W'(us3_r) + SUM_W'(vc3_r) + $signed(SUM_W'(cv3_r) << TRIG_FRAC_BITS);
  end

  // Stage 5: truncate, saturate and route back to the axes
  par_round_sat u_round_a (
    .sum   (suma4_r),
    .coord (coord_a)
  );

  par_round_sat u_round_b (
    .sum   (sumb4_r),
    .coord (coord_b)
  );

  always_comb begin
    out_nxt.out_x          = p4_r.in_x;
    out_nxt.out_y          = p4_r.in_y;
    out_nxt.out_z          = p4_r.in_z;
    out_nxt.last_point_out = p4_r.last_point;
    case (p4_r.func)
      FUNC_ROT_X: begin
        out_nxt.out_y = coord_a;
        out_nxt.out_z = coord_b;
      end
      FUNC_ROT_Y: begin
        out_nxt.out_z = coord_a;
        out_nxt.out_x = coord_b;
      end
      FUNC_ROT_Z: begin
        out_nxt.out_x = coord_a;
        out_nxt.out_y = coord_b;
      end
      default: ;
    endcase
  end

  // Advance stage payloads; hold them while stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_r   <= in_data;
      deg1_r <= deg1_nxt;
      du1_r  <= du1_nxt;
      dv1_r  <= dv1_nxt;
      cu1_r  <= cu1_nxt;
      cv1_r  <= cv1_nxt;
    end
    if (rdy2) begin
      p2_r    <= p1_r;
      trig2_r <= trig2_nxt;
      du2_r   <= du1_r;
      dv2_r   <= dv1_r;
      cu2_r   <= cu1_r;
      cv2_r   <= cv1_r;
    end
    if (rdy3) begin
      p3_r  <= p2_r;
      uc3_r <= du2_r * trig2_r.cos_val;
      vs3_r <= dv2_r * trig2_r.sin_val;
      us3_r <= du2_r * trig2_r.sin_val;
      vc3_r <= dv2_r * trig2_r.cos_val;
      cu3_r <= cu2_r;
      cv3_r <= cv2_r;
    end
    if (rdy4) begin
      p4_r    <= p3_r;
      suma4_r <= suma4_nxt;
      sumb4_r <= sumb4_nxt;
    end
    if (rdy5) begin
      out_r <= out_nxt;
    end
  end

  // Input stalls only when every stage holds a request
  `ASSERT_IMPLY(a_stall_full, clk, rst_n, in_stall,
                v1_r && v2_r && v3_r && v4_r && v5_r, "input stalled with a free stage")
  // A blocked stage keeps its request
  `ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_r && !rdy2,
               v1_r && $stable(p1_r), "stage 1 request lost while blocked")
  // A request leaving stage 4 always lands in the output register
  `ASSERT_NEXT(a_stage4_move, clk, rst_n, v4_r && rdy5, v5_r, "request dropped at output")
  // The rotation axis coordinate passes through untouched
  `ASSERT_NEXT(a_axis_pass, clk, rst_n, v4_r && rdy5 && (p4_r.func == FUNC_ROT_Y),
               out_data.out_y == $past(p4_r.in_y), "axis coordinate altered")

endmodule

// ===== rtl/par_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_trig
// Sine and cosine of a reduced whole-degree angle from the quarter table.
// ----------------------------------------------------------------------------
module par_trig
  import par_pkg::*;
(
  input  logic [DEG_W-1:0] deg,
  output par_trig_t        trig
);

  logic [DEG_W:0] deg_ext;
  logic [DEG_W:0] deg_plus;
  logic [DEG_W:0] deg_cos;

  // Shift by a quarter turn for the cosine, wrap at a full turn
  always_comb begin
    deg_ext  = {1'b0, deg};
    deg_plus = deg_ext + DEG_QUARTER;
    deg_cos  = (deg_plus >= DEG_FULL) ? deg_plus - DEG_FULL : deg_plus;
  end

  assign trig.sin_val = sine_lookup(deg_ext);
  assign trig.cos_val = sine_lookup(deg_cos);

endmodule

// ===== rtl/par_round_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_round_sat
// Truncate a fixed-point sum toward zero and saturate to the coordinate range.
// ----------------------------------------------------------------------------
module par_round_sat
  import par_pkg::*;
(
  input  logic signed [SUM_W-1:0]      sum,
  output logic signed [COORD_BITS-1:0] coord
);

  localparam logic [SUM_W-1:0] TRUNC_BIAS =
    {{(SUM_W-TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};
  localparam logic signed [QUOT_W-1:0] Q_MAX =
    {{(QUOT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [QUOT_W-1:0] Q_MIN =
    {{(QUOT_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [SUM_W-1:0]  biased;
  logic signed [QUOT_W-1:0] quot;

  // Bias negative sums so the shift rounds toward zero, then clamp
  always_comb begin
    biased = sum + $signed(sum[SUM_W-1] ? TRUNC_BIAS : '0);
    quot   = $signed(biased[SUM_W-1:TRIG_FRAC_BITS]);
    if (quot > Q_MAX) begin
      coord = Q_MAX[COORD_BITS-1:0];
    end else if (quot < Q_MIN) begin
      coord = Q_MIN[COORD_BITS-1:0];
    end else begin
      coord = quot[COORD_BITS-1:0];
    end
  end

endmodule
